/* rtl/core/pol_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pol_pkg: shared types for the positional ordered list unit
// Request codes, cell operation codes and the control bundle that the
// sequencer sends down the cell chain.
// ----------------------------------------------------------------------------
package pol_pkg;

  typedef enum logic [1:0] {
    CMD_GET    = 2'd0,
    CMD_LOCATE = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_ROTATE,
    OP_INSERT,
    OP_DELETE
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // pos0 is the 0-based slot the operation targets
  typedef struct packed {
    cell_op_e   op;
    logic [7:0] pos0;
    logic [7:0] value;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* rtl/core/pol_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pol_cell: one slot of the list
// Holds one element and, as told by the sequencer, keeps it, takes its
// right neighbour's (rotate, delete), its left neighbour's or the new
// value (insert).
// ----------------------------------------------------------------------------
module pol_cell
  import pol_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  wire logic       clk_i,
  input  wire cell_ctl_t  ctl_i,
  input  wire logic [7:0] left_i,
  input  wire logic [7:0] right_i,
  output logic      [7:0] elem_o
);

  localparam logic [7:0] IndexB = 8'(INDEX);

  logic [7:0] elem_q, elem_d;

  always_comb begin
    elem_d = elem_q;
    unique case (ctl_i.op)
      OP_HOLD:   elem_d = elem_q;
      OP_ROTATE: elem_d = right_i;
      OP_INSERT: begin
        if (IndexB == ctl_i.pos0) begin
          elem_d = ctl_i.value;
        end else if (IndexB > ctl_i.pos0) begin
          elem_d = left_i;
        end
      end
      OP_DELETE: begin
        if (IndexB >= ctl_i.pos0) begin
          elem_d = right_i;
        end
      end
      default: elem_d = elem_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  assign elem_o = elem_q;

endmodule
`default_nettype wire

/* rtl/core/pol_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pol_ctrl: request sequencer
// Checks positions against the length, drives the cell chain and walks
// the ring once for get and locate, watching the head cell.
// ----------------------------------------------------------------------------
module pol_ctrl
  import pol_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] command_i,
  input  wire logic [7:0] position_i,
  input  wire logic [7:0] value_i,
  input  wire logic [7:0] head_i,
  output cell_ctl_t       ctl_o,
  output logic            done_o,
  output logic            status_o,
  output logic      [7:0] read_value_o,
  output logic      [7:0] found_position_o,
  output logic      [4:0] list_length_o
);

  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LenW = $clog2(CAPACITY + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);
  localparam logic [LenW-1:0] CapLen  = LenW'(CAPACITY);

  state_e          state_q, state_d;
  logic [IdxW-1:0] scan_q, scan_d;
  logic [LenW-1:0] len_q, len_d;
  cmd_e            cmd_q, cmd_d;
  logic [7:0]      pos0_q, pos0_d;
  logic [7:0]      val_q, val_d;
  logic            hit_q, hit_d;
  logic [7:0]      rd_q, rd_d;
  logic [7:0]      fpos_q, fpos_d;
  logic            done_q, done_d;
  logic            status_q, status_d;
  logic [7:0]      rdv_q, rdv_d;
  logic [7:0]      fnd_q, fnd_d;
  logic [4:0]      olen_q, olen_d;

  logic [8:0] pos9, len9;
  logic       rd_ok, ins_ok;
  logic       hit_now;
  cmd_e       cmd_in;

  assign cmd_in = cmd_e'(command_i);
  assign pos9   = {1'b0, position_i};
  assign len9   = 9'(len_q);
  assign rd_ok  = (position_i != 8'd0) && (pos9 <= len9);
  assign ins_ok = (position_i != 8'd0) && (pos9 <= len9 + 9'd1) && (len_q < CapLen);

  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    len_d     = len_q;
    cmd_d     = cmd_q;
    pos0_d    = pos0_q;
    val_d     = val_q;
    hit_d     = hit_q;
    rd_d      = rd_q;
    fpos_d    = fpos_q;
    done_d    = 1'b0;
    status_d  = status_q;
    rdv_d     = rdv_q;
    fnd_d     = fnd_q;
    olen_d    = olen_q;
    hit_now   = 1'b0;
    ctl_o.op    = OP_HOLD;
    ctl_o.pos0  = position_i - 8'd1;
    ctl_o.value = value_i;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d  = cmd_in;
          pos0_d = position_i - 8'd1;
          val_d  = value_i;
          hit_d  = 1'b0;
          rd_d   = 8'd0;
          fpos_d = 8'd0;
          // error unless overridden below
          done_d   = 1'b1;
          status_d = 1'b1;
          rdv_d    = 8'd0;
          fnd_d    = 8'd0;
          olen_d   = 5'(len_q);
          unique case (cmd_in)
            CMD_GET: begin
              if (rd_ok) begin
                done_d  = 1'b0;
                state_d = ST_SCAN;
                scan_d  = '0;
              end
            end
            CMD_LOCATE: begin
              if (len_q != '0) begin
                done_d  = 1'b0;
                state_d = ST_SCAN;
                scan_d  = '0;
              end
            end
            CMD_INSERT: begin
              if (ins_ok) begin
                ctl_o.op = OP_INSERT;
                len_d    = len_q + LenW'(1);
                status_d = 1'b0;
                olen_d   = 5'(len_d);
              end
            end
            CMD_DELETE: begin
              if (rd_ok) begin
                ctl_o.op = OP_DELETE;
                len_d    = len_q - LenW'(1);
                status_d = 1'b0;
                olen_d   = 5'(len_d);
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // the ring turns one slot a cycle, head holds slot scan_q
        ctl_o.op = OP_ROTATE;
        if (!hit_q) begin
          if (cmd_q == CMD_GET) begin
            hit_now = (8'(scan_q) == pos0_q);
          end else begin
            hit_now = (LenW'(scan_q) < len_q) && (head_i == val_q);
          end
        end
        if (hit_now) begin
          hit_d  = 1'b1;
          rd_d   = head_i;
          fpos_d = 8'(scan_q) + 8'd1;
        end
        if (scan_q == LastIdx) begin
          state_d  = ST_IDLE;
          done_d   = 1'b1;
          status_d = !hit_d;
          rdv_d    = (cmd_q == CMD_GET) ? rd_d : 8'd0;
          fnd_d    = (cmd_q == CMD_LOCATE) ? fpos_d : 8'd0;
          olen_d   = 5'(len_q);
        end else begin
          scan_d = scan_q + IdxW'(1);
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      done_q  <= done_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q   <= scan_d;
    cmd_q    <= cmd_d;
    pos0_q   <= pos0_d;
    val_q    <= val_d;
    rd_q     <= rd_d;
    fpos_q   <= fpos_d;
    status_q <= status_d;
    rdv_q    <= rdv_d;
    fnd_q    <= fnd_d;
    olen_q   <= olen_d;
  end

  assign busy             = (state_q == ST_SCAN);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign read_value_o     = rdv_q;
  assign found_position_o = fnd_q;
  assign list_length_o    = olen_q;

endmodule
`default_nettype wire

/* rtl/core/positional_ordered_list_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_ordered_list_unit: bounded ordered list of bytes
// Get, locate, insert and delete by 1-based position on a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   An item (command_i, position_i, value_i) is taken at a clock edge with
//   start high and busy low. Each item gives exactly one result, shown for
//   one cycle with done_o high on status_o, read_value_o, found_position_o
//   and list_length_o; the receiver must take it then.
//   Insert, delete and every rejected request answer in the cycle after
//   acceptance and never raise busy, so one such item can go every cycle.
//   Get and locate turn the cell ring once round, one slot a cycle, while
//   the sequencer watches the head cell: busy stays high for the whole
//   turn and the result is registered as the last slot leaves the head.
//   A new item can be taken in the cycle its predecessor's result shows.
//   Reset empties the list; cell contents are not cleared and are only
//   ever read below the current length.
// ----------------------------------------------------------------------------
module positional_ordered_list_unit
  import pol_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] command_i,
  input  wire logic [7:0] position_i,
  input  wire logic [7:0] value_i,
  output logic            done_o,
  output logic            status_o,
  output logic      [7:0] read_value_o,
  output logic      [7:0] found_position_o,
  output logic      [4:0] list_length_o
);

  cell_ctl_t  ctl;
  logic [7:0] elem [CAPACITY];

  pol_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .head_i          (elem[0]),
    .ctl_o           (ctl),
    .done_o          (done_o),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .found_position_o(found_position_o),
    .list_length_o   (list_length_o)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [7:0] left_w, right_w;

    if (i == 0) begin : g_first
      assign left_w = 8'h00;
    end else begin : g_left
      assign left_w = elem[i-1];
    end

    // last cell closes the ring
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = elem[0];
    end else begin : g_right
      assign right_w = elem[i+1];
    end

    pol_cell #(
      .INDEX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .left_i (left_w),
      .right_i(right_w),
      .elem_o (elem[i])
    );
  end

endmodule
`default_nettype wire

/* bench/tb_positional_ordered_list_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_ordered_list_unit: self-checking bench for the list unit
// Directed and random get, locate, insert and delete requests are driven
// through the start/busy handshake. Every answer on the done strobe is
// checked against a shadow copy of the list kept by the bench.
// ----------------------------------------------------------------------------
module tb_positional_ordered_list_unit;
  import pol_pkg::*;

  localparam int LIST_CAP       = 16;
  localparam int ITEMS_PER_MODE = 310;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [LIST_CAP-1:0][7:0] slot;
    logic [4:0]               count;
  } list_image_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_value;
    logic [7:0] found_position;
    logic [4:0] list_length;
  } list_answer_t;

  typedef struct {
    cmd_e        cmd;
    logic [7:0]  pos;
    logic [7:0]  val;
    int unsigned idle_pct;
    bit          drain;
  } list_request_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] command_i = 2'd0;
  logic [7:0] position_i = 8'd0;
  logic [7:0] value_i = 8'd0;
  logic       done_o;
  logic       status_o;
  logic [7:0] read_value_o;
  logic [7:0] found_position_o;
  logic [4:0] list_length_o;

  list_request_t pending_requests[$];
  list_answer_t  expected_answers[$];

  list_image_t   plan_image;
  list_image_t   shadow_image;
  list_answer_t  plan_answer;
  list_answer_t  issued_answer;
  list_answer_t  due_answer;
  list_request_t next_request;

  int          in_flight;
  int          mismatches;
  int          answers_seen;
  int          quiet_cycles;
  int unsigned cur_idle_pct;
  bit          drain_next;
  bit          growing;

  positional_ordered_list_unit #(
    .CAPACITY(LIST_CAP)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .found_position_o(found_position_o),
    .list_length_o   (list_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // applies one request to a list image and returns the answer it gives
  function automatic list_answer_t predict_list_answer(inout list_image_t img,
                                                       input cmd_e cmd,
                                                       input logic [7:0] pos,
                                                       input logic [7:0] val);
    list_answer_t ans;
    int           k;
    bit           hit;
    ans = '0;
    ans.status = 1'b1;
    hit = 1'b0;
    case (cmd)
      CMD_GET: begin
        if (pos >= 1 && pos <= img.count) begin
          ans.read_value = img.slot[pos-1];
          ans.status = 1'b0;
        end
      end
      CMD_LOCATE: begin
        for (k = 0; k < img.count; k++) begin
          if (!hit && img.slot[k] == val) begin
            hit = 1'b1;
            ans.found_position = 8'(k + 1);
            ans.status = 1'b0;
          end
        end
      end
      CMD_INSERT: begin
        if (pos >= 1 && pos <= img.count + 1 && img.count < LIST_CAP) begin
          for (k = img.count; k > pos - 1; k--) begin
            img.slot[k] = img.slot[k-1];
          end
          img.slot[pos-1] = val;
          img.count = 5'(img.count + 5'd1);
          ans.status = 1'b0;
        end
      end
      default: begin
        if (pos >= 1 && pos <= img.count) begin
          for (k = pos - 1; k + 1 < img.count; k++) begin
            img.slot[k] = img.slot[k+1];
          end
          img.count = 5'(img.count - 5'd1);
          ans.status = 1'b0;
        end
      end
    endcase
    ans.list_length = img.count;
    return ans;
  endfunction

  task automatic queue_request(input cmd_e cmd, input logic [7:0] pos,
                               input logic [7:0] val);
    list_request_t req;
    plan_answer = predict_list_answer(plan_image, cmd, pos, val);
    req.cmd = cmd;
    req.pos = pos;
    req.val = val;
    req.idle_pct = cur_idle_pct;
    req.drain = drain_next;
    drain_next = 1'b0;
    pending_requests.push_back(req);
  endtask

  // mostly legal positions, with zero, just past the end and far out mixed in
  function automatic logic [7:0] pick_position(input int hi);
    int r;
    r = $urandom_range(99);
    if (r < 80) return (hi >= 1) ? 8'($urandom_range(hi, 1)) : 8'd1;
    else if (r < 88) return 8'(hi + 1);
    else if (r < 92) return 8'd0;
    else if (r < 96) return 8'd255;
    else return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_value(input bit from_list);
    if (from_list && plan_image.count != 0 && $urandom_range(99) < 60)
      return plan_image.slot[$urandom_range(plan_image.count - 1)];
    if ($urandom_range(99) < 30) return 8'($urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  task automatic queue_random_request();
    int r;
    int ins_w;
    int del_w;
    if (plan_image.count == LIST_CAP && growing && $urandom_range(99) < 30)
      growing = 1'b0;
    else if (plan_image.count == 0 && !growing && $urandom_range(99) < 30)
      growing = 1'b1;
    else if ($urandom_range(99) < 2)
      growing = !growing;
    ins_w = growing ? 45 : 15;
    del_w = growing ? 15 : 45;
    r = $urandom_range(99);
    if (r < ins_w)
      queue_request(CMD_INSERT, pick_position(plan_image.count + 1), pick_value(1'b0));
    else if (r < ins_w + del_w)
      queue_request(CMD_DELETE, pick_position(plan_image.count), 8'($urandom_range(255)));
    else if (r < ins_w + del_w + 20)
      queue_request(CMD_GET, pick_position(plan_image.count), 8'($urandom_range(255)));
    else
      queue_request(CMD_LOCATE, 8'($urandom_range(255)), pick_value(1'b1));
  endtask

  // driver: presents the next item once the current one has been taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        issued_answer = predict_list_answer(shadow_image, cmd_e'(command_i),
                                            position_i, value_i);
        expected_answers.push_back(issued_answer);
        in_flight++;
      end
      if (done_o) in_flight--;
      if (start && busy) begin
        // hold the item until it is taken
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].drain && in_flight != 0) &&
                   $urandom_range(99) >= pending_requests[0].idle_pct) begin
        next_request = pending_requests.pop_front();
        start      <= 1'b1;
        command_i  <= next_request.cmd;
        position_i <= next_request.pos;
        value_i    <= next_request.val;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobe is checked against the oldest answer due
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if (done_o) begin
        answers_seen++;
        if (expected_answers.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d with no item outstanding: status %0d rd %0d pos %0d len %0d",
                     answers_seen, status_o, read_value_o, found_position_o, list_length_o);
          mismatches++;
        end else begin
          due_answer = expected_answers.pop_front();
          if (status_o !== due_answer.status || read_value_o !== due_answer.read_value ||
              found_position_o !== due_answer.found_position ||
              list_length_o !== due_answer.list_length) begin
            if (mismatches < 10)
              $display("result %0d: exp status %0d rd %0d pos %0d len %0d, got %0d %0d %0d %0d",
                       answers_seen, due_answer.status, due_answer.read_value,
                       due_answer.found_position, due_answer.list_length,
                       status_o, read_value_o, found_position_o, list_length_o);
            mismatches++;
          end
        end
      end
      if ((start && !busy) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk_i);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int mode;
    int n;
    plan_image = '0;
    shadow_image = '0;
    in_flight = 0;
    mismatches = 0;
    answers_seen = 0;
    quiet_cycles = 0;
    cur_idle_pct = 0;
    drain_next = 1'b0;
    growing = 1'b1;

    // empty list: every position is out of range, nothing to find
    queue_request(CMD_GET,    8'd0,   8'd0);
    queue_request(CMD_GET,    8'd1,   8'd0);
    queue_request(CMD_DELETE, 8'd1,   8'd0);
    queue_request(CMD_LOCATE, 8'd0,   8'd0);
    queue_request(CMD_INSERT, 8'd0,   8'h11);
    queue_request(CMD_INSERT, 8'd2,   8'h22);
    queue_request(CMD_INSERT, 8'd1,   8'h00);
    queue_request(CMD_INSERT, 8'd2,   8'hFF);
    queue_request(CMD_INSERT, 8'd1,   8'h5A);
    queue_request(CMD_INSERT, 8'd3,   8'h00);
    queue_request(CMD_INSERT, 8'd255, 8'hA5);
    // duplicates: locate must give the first one
    queue_request(CMD_LOCATE, 8'd255, 8'h00);
    queue_request(CMD_LOCATE, 8'd0,   8'hFF);
    queue_request(CMD_LOCATE, 8'd7,   8'h33);
    queue_request(CMD_GET,    8'd4,   8'hFF);
    queue_request(CMD_GET,    8'd5,   8'h00);
    queue_request(CMD_GET,    8'd255, 8'h00);
    queue_request(CMD_DELETE, 8'd5,   8'h00);
    queue_request(CMD_DELETE, 8'd0,   8'h00);
    queue_request(CMD_DELETE, 8'd4,   8'h00);
    queue_request(CMD_DELETE, 8'd1,   8'h00);
    queue_request(CMD_INSERT, 8'd3,   8'hC3);
    queue_request(CMD_GET,    8'd1,   8'h00);

    // idle mixes: none, heavy, none, light
    for (mode = 0; mode < 4; mode++) begin
      cur_idle_pct = (mode == 1) ? 83 : (mode == 3) ? 27 : 0;
      drain_next = 1'b1;
      for (n = 0; n < ITEMS_PER_MODE; n++) begin
        if ($urandom_range(99) == 0) drain_next = 1'b1;
        queue_random_request();
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || start || expected_answers.size() != 0)
      @(negedge clk_i);
    repeat (LIST_CAP + 4) @(negedge clk_i);
    if (expected_answers.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* positional_ordered_list_unit.f */
rtl/core/pol_pkg.sv
rtl/core/pol_cell.sv
rtl/core/pol_ctrl.sv
rtl/core/positional_ordered_list_unit.sv
bench/tb_positional_ordered_list_unit.sv
